/* hdl/dtem_pkg.sv */
`default_nettype none

package dtem_pkg;

  // Configuration register indexes
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  localparam logic [13:0] MIN_YEAR_RST = 14'd2000;
  localparam logic [13:0] MAX_YEAR_RST = 14'd2100;

  // String kinds
  localparam logic KIND_DATE = 1'b0;
  localparam logic KIND_TIME = 1'b1;

  // ASCII codes
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Character positions in "DD/MM/YYYY"
  localparam logic [3:0] POS_DAY_HI  = 4'd0;
  localparam logic [3:0] POS_DAY_LO  = 4'd1;
  localparam logic [3:0] POS_D_SEP1  = 4'd2;
  localparam logic [3:0] POS_MON_HI  = 4'd3;
  localparam logic [3:0] POS_MON_LO  = 4'd4;
  localparam logic [3:0] POS_D_SEP2  = 4'd5;
  localparam logic [3:0] POS_YEAR_HI = 4'd6;
  localparam logic [3:0] POS_D_LAST  = 4'd9;

  // Character positions in "HH:MM"
  localparam logic [3:0] POS_HOUR_HI = 4'd0;
  localparam logic [3:0] POS_HOUR_LO = 4'd1;
  localparam logic [3:0] POS_T_SEP   = 4'd2;
  localparam logic [3:0] POS_MIN_HI  = 4'd3;
  localparam logic [3:0] POS_T_LAST  = 4'd4;

  localparam logic [3:0] POS_MAX = 4'd15;

  // Calendar constants
  localparam logic [6:0]  HOUR_MAX    = 7'd23;
  localparam logic [6:0]  MINUTE_MAX  = 7'd59;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [22:0] DAYS_PER_ERA = 23'd146097;
  // one era of offset plus the days from 0000-03-01 to 1970-01-01,
  // plus one because the day of month enters the day count one-based
  localparam logic signed [23:0] DAYS_BIAS = 24'sd865566;
  localparam logic signed [34:0] MIN_PER_DAY = 35'sd1440;

  // Multiply-accumulate one decimal digit, truncated to the field width
  function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
    logic [10:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {7'b0, d};
    return t[6:0];
  endfunction

  function automatic logic [13:0] acc14(input logic [13:0] v, input logic [3:0] d);
    logic [17:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {14'b0, d};
    return t[13:0];
  endfunction

  // Gregorian leap year; y / 100 by reciprocal, exact below 2^14
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [14:0] r;
    prod = {13'b0, y} * 27'd5243;
    q    = prod[26:19];
    r    = {1'b0, y} - ({7'b0, q} * 15'd100);
    return ((y[1:0] == 2'b00) && (r != 15'd0)) || ((r == 15'd0) && (q[1:0] == 2'b00));
  endfunction

  // Days in month, February without the leap day
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd2:                         n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
      default:                      n = 5'd31;
    endcase
    return n;
  endfunction

  // First day of month in a March-based year, month index 0 = March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/date_time_to_epoch_minutes.sv */
`default_nettype none
// Date and time string to minutes since 1970-01-01 00:00.
// Input channel: one ASCII character per transfer (in_character), with
// in_kind (0 = "DD/MM/YYYY" date, 1 = "HH:MM" time) and in_last_char marking
// the end of a string. Only the last character of a time string produces a
// result; all other characters just update the parser state.
// Result channel: out_valid_res is 1 when the latest date and this time both
// validated; out_total_minutes is the signed minute count, zero otherwise.
// Configuration channel: cfg_index 0 writes min_year, 1 writes max_year;
// cfg_ready is always high.
// Throughput: one character per cycle while the output is not stalled. A
// result passes the six-stage calendar pipeline (era, year of era, day of
// era, day count, minute count) into the output register.
// A stalled receiver freezes the whole pipeline and drops in_ready in the
// same cycle; nothing is lost. Reset empties the pipeline, clears the
// parser and loads years 2000 and 2100 into the window registers.
module date_time_to_epoch_minutes (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_character,
  input  wire logic               in_kind,
  input  wire logic               in_last_char,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_valid_res,
  output logic signed [32:0]      out_total_minutes,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [13:0]        cfg_data
);
  import dtem_pkg::*;

  // Configuration
  logic [13:0] min_year_r;
  logic [13:0] max_year_r;

  // Parser state
  logic [3:0]  char_pos_r;
  logic [6:0]  day_value_r, month_value_r, hour_value_r, minute_value_r;
  logic [13:0] year_value_r;
  logic        fmt_err_r;
  logic        date_chk_r, date_fmt_r, date_ok_r;

  // Parser next values
  logic        in_xfer, pipe_en;
  logic        is_digit, char_err, fmt_err_cur;
  logic [3:0]  dval;
  logic [6:0]  day_nxt, month_nxt, hour_nxt, minute_nxt;
  logic [13:0] year_nxt;
  logic        date_valid, leap, date_ok_eff, time_ok;
  logic [4:0]  max_day;

  // Pipeline stages
  logic        s1_vld_r, s1_ok_r;
  logic [13:0] s1_year_r;
  logic [3:0]  s1_month_r;
  logic [6:0]  s1_day_r;
  logic [4:0]  s1_hour_r;
  logic [5:0]  s1_min_r;

  logic        s2_vld_r, s2_ok_r;
  logic [14:0] s2_ys_r;
  logic [5:0]  s2_era_r;
  logic [8:0]  s2_doy_r;
  logic [10:0] s2_hm_r;

  logic        s3_vld_r, s3_ok_r;
  logic [8:0]  s3_yoe_r;
  logic [5:0]  s3_era_r;
  logic [8:0]  s3_doy_r;
  logic [10:0] s3_hm_r;

  logic        s4_vld_r, s4_ok_r;
  logic [17:0] s4_doe_r;
  logic [5:0]  s4_era_r;
  logic [10:0] s4_hm_r;

  logic              s5_vld_r, s5_ok_r;
  logic signed [23:0] s5_days_r;
  logic [10:0]       s5_hm_r;

  logic              out_vld_r, out_res_r;
  logic signed [32:0] out_total_r;

  logic [14:0] ys_w;
  logic [21:0] era_prod;
  logic [3:0]  mp_w;
  logic [8:0]  doy_w;
  logic [10:0] hm_w;
  logic [14:0] yoe_w;
  logic [17:0] y365_w;
  logic [14:0] c100_prod;
  logic [17:0] doe_w;
  logic [22:0] era_days_w;
  logic signed [23:0] days_w;
  logic signed [34:0] total_w;

  assign pipe_en   = !out_vld_r || out_ready;
  assign in_ready  = pipe_en;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= MIN_YEAR_RST;
      max_year_r <= MAX_YEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_YEAR: min_year_r <= cfg_data;
        CFG_MAX_YEAR: max_year_r <= cfg_data;
        default:      min_year_r <= min_year_r;
      endcase
    end
  end

  // Check the character against its position and accumulate digits
  always_comb begin
    is_digit   = (in_character >= CH_ZERO) && (in_character <= CH_NINE);
    dval       = is_digit ? in_character[3:0] : 4'd0;
    char_err   = 1'b0;
    day_nxt    = day_value_r;
    month_nxt  = month_value_r;
    year_nxt   = year_value_r;
    hour_nxt   = hour_value_r;
    minute_nxt = minute_value_r;
    if (in_kind == KIND_DATE) begin
      if ((char_pos_r == POS_D_SEP1) || (char_pos_r == POS_D_SEP2)) begin
        char_err = (in_character != CH_SLASH);
      end else if (char_pos_r <= POS_D_LAST) begin
        if (!is_digit) begin
          char_err = 1'b1;
        end else begin
          case (char_pos_r)
            POS_DAY_HI:  day_nxt   = {3'b000, dval};
            POS_DAY_LO:  day_nxt   = acc7(day_value_r, dval);
            POS_MON_HI:  month_nxt = {3'b000, dval};
            POS_MON_LO:  month_nxt = acc7(month_value_r, dval);
            POS_YEAR_HI: year_nxt  = {10'b0, dval};
            default:     year_nxt  = acc14(year_value_r, dval);
          endcase
        end
      end else begin
        char_err = 1'b1;
      end
    end else begin
      if (char_pos_r == POS_T_SEP) begin
        char_err = (in_character != CH_COLON);
      end else if (char_pos_r <= POS_T_LAST) begin
        if (!is_digit) begin
          char_err = 1'b1;
        end else begin
          case (char_pos_r)
            POS_HOUR_HI: hour_nxt   = {3'b000, dval};
            POS_HOUR_LO: hour_nxt   = acc7(hour_value_r, dval);
            POS_MIN_HI:  minute_nxt = {3'b000, dval};
            default:     minute_nxt = acc7(minute_value_r, dval);
          endcase
        end
      end else begin
        char_err = 1'b1;
      end
    end
    fmt_err_cur = fmt_err_r || char_err;
  end

  // Validate the stored date in the cycle after its last character; check the time
  always_comb begin
    leap    = is_leap(year_value_r);
    max_day = month_days(month_value_r[3:0]);
    if ((month_value_r[3:0] == MONTH_FEB) && leap) begin
      max_day = 5'd29;
    end
    date_valid = (year_value_r >= min_year_r) && (year_value_r <= max_year_r) &&
                 (month_value_r >= 7'd1) && (month_value_r <= 7'd12) &&
                 (day_value_r >= 7'd1) && (day_value_r <= {2'b00, max_day});
    date_ok_eff = date_chk_r ? (date_fmt_r && date_valid) : date_ok_r;
    time_ok     = !fmt_err_cur && date_ok_eff && (char_pos_r == POS_T_LAST) &&
                  (hour_nxt <= HOUR_MAX) && (minute_nxt <= MINUTE_MAX);
  end

  // Advance the parser on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r     <= 4'd0;
      fmt_err_r      <= 1'b0;
      day_value_r    <= 7'd0;
      month_value_r  <= 7'd0;
      year_value_r   <= 14'd0;
      hour_value_r   <= 7'd0;
      minute_value_r <= 7'd0;
    end else if (in_xfer) begin
      day_value_r    <= day_nxt;
      month_value_r  <= month_nxt;
      year_value_r   <= year_nxt;
      hour_value_r   <= hour_nxt;
      minute_value_r <= minute_nxt;
      if (in_last_char) begin
        char_pos_r <= 4'd0;
        fmt_err_r  <= 1'b0;
      end else begin
        char_pos_r <= (char_pos_r == POS_MAX) ? POS_MAX : char_pos_r + 4'd1;
        fmt_err_r  <= fmt_err_cur;
      end
    end
  end

  // Hold the date verdict; drop it after every time result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_chk_r <= 1'b0;
      date_fmt_r <= 1'b0;
      date_ok_r  <= 1'b0;
    end else begin
      date_chk_r <= 1'b0;
      date_ok_r  <= date_ok_eff;
      if (in_xfer && in_last_char) begin
        if (in_kind == KIND_DATE) begin
          date_chk_r <= 1'b1;
          date_fmt_r <= !fmt_err_cur && (char_pos_r == POS_D_LAST);
        end else begin
          date_ok_r <= 1'b0;
        end
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_r  <= in_xfer && in_last_char && (in_kind == KIND_TIME);
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      out_vld_r <= s5_vld_r;
    end
  end

  // Shift the year back for January and February; find the era and the minute of day.
  // Day of year stays one-based here; the bias takes the extra day off.
  always_comb begin
    ys_w     = {1'b0, s1_year_r} + 15'd400 - ((s1_month_r <= MONTH_FEB) ? 15'd1 : 15'd0);
    era_prod = {11'b0, ys_w[14:4]} * 22'd1311;
    mp_w     = (s1_month_r > MONTH_FEB) ? (s1_month_r - 4'd3) : (s1_month_r + 4'd9);
    doy_w    = month_start(mp_w) + {2'b00, s1_day_r};
    hm_w     = {s1_hour_r, 6'b000000} - {4'b0000, s1_hour_r, 2'b00} + {5'b00000, s1_min_r};
  end

  // Year of era
  assign yoe_w = s2_ys_r - ({1'b0, s2_era_r, 8'b0} + {2'b0, s2_era_r, 7'b0} +
                            {5'b0, s2_era_r, 4'b0});

  // Day of era
  always_comb begin
    y365_w    = {9'b0, s3_yoe_r} * 18'd365;
    c100_prod = {6'b0, s3_yoe_r} * 15'd41;
    doe_w     = y365_w + {11'b0, s3_yoe_r[8:2]} - {15'b0, c100_prod[14:12]} +
                {9'b0, s3_doy_r};
  end

  // Days and minutes since the epoch
  always_comb begin
    era_days_w = {17'b0, s4_era_r} * DAYS_PER_ERA;
    days_w     = $signed({1'b0, era_days_w}) + $signed({6'b0, s4_doe_r}) - DAYS_BIAS;
    total_w    = 35'(s5_days_r) * MIN_PER_DAY + $signed({24'b0, s5_hm_r});
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_ok_r     <= time_ok;
      s1_year_r   <= year_value_r;
      s1_month_r  <= month_value_r[3:0];
      s1_day_r    <= day_value_r;
      s1_hour_r   <= hour_nxt[4:0];
      s1_min_r    <= minute_nxt[5:0];

      s2_ok_r     <= s1_ok_r;
      s2_ys_r     <= ys_w;
      s2_era_r    <= era_prod[20:15];
      s2_doy_r    <= doy_w;
      s2_hm_r     <= hm_w;

      s3_ok_r     <= s2_ok_r;
      s3_yoe_r    <= yoe_w[8:0];
      s3_era_r    <= s2_era_r;
      s3_doy_r    <= s2_doy_r;
      s3_hm_r     <= s2_hm_r;

      s4_ok_r     <= s3_ok_r;
      s4_doe_r    <= doe_w;
      s4_era_r    <= s3_era_r;
      s4_hm_r     <= s3_hm_r;

      s5_ok_r     <= s4_ok_r;
      s5_days_r   <= days_w;
      s5_hm_r     <= s4_hm_r;

      out_res_r   <= s5_ok_r;
      out_total_r <= s5_ok_r ? total_w[32:0] : 33'sd0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_valid_res     = out_res_r;
  assign out_total_minutes = out_total_r;

  // Checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_total_minutes == 33'sd0)
    else $error("invalid result carries a nonzero minute count");

  a_time_end_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_char && (in_kind == KIND_TIME) |=> s1_vld_r)
    else $error("time string end did not enter the pipeline");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_ok_r |-> (s1_month_r <= 4'd12) && (s1_hour_r <= 5'd23) &&
                            (s1_min_r <= 6'd59))
    else $error("validated item with out-of-range fields");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_char |=> (char_pos_r == 4'd0) && !fmt_err_r)
    else $error("parser did not restart after a string end");

  a_date_chk_once: assert property (@(posedge clk) disable iff (!rst_n)
    date_chk_r && !$past(in_xfer && in_last_char) |-> 1'b0)
    else $error("date check pending without a date end");

endmodule

`default_nettype wire
